// File: rtl/ppu_pkg.sv
// Shared types and constants for the palette pixel unpacker.
`default_nettype none
package ppu_pkg;

    // Item kinds on the input tuser.
    localparam logic C_OP_PALETTE = 1'b0;
    localparam logic C_OP_DATA    = 1'b1;

    // Configuration register indexes.
    localparam logic C_REG_BPP   = 1'b0;
    localparam logic C_REG_WIDTH = 1'b1;

    // Supported pixel depths.
    localparam logic [5:0] C_BPP_1  = 6'd1;
    localparam logic [5:0] C_BPP_4  = 6'd4;
    localparam logic [5:0] C_BPP_8  = 6'd8;
    localparam logic [5:0] C_BPP_24 = 6'd24;
    localparam logic [5:0] C_BPP_32 = 6'd32;

    localparam logic [5:0] C_BPP_RESET   = 6'd8;
    localparam logic [8:0] C_WIDTH_RESET = 9'd32;

    // Widest row that the column logic honours.
    localparam int C_MAX_WIDTH = 256;

    localparam logic [7:0] C_ALPHA_OPAQUE = 8'hFF;

    // Command queue depth between front and back.
    localparam int C_QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        K_WRITE  = 3'd0,
        K_IDX1   = 3'd1,
        K_IDX4   = 3'd2,
        K_IDX8   = 3'd3,
        K_DIRECT = 3'd4
    } t_kind;

    // payload layout:
    //   K_WRITE : [31:24] entry index, [23:16] blue, [15:8] green, [7:0] red
    //   K_IDX*  : [7:0] data byte
    //   K_DIRECT: [31:24] alpha, [23:16] blue, [15:8] green, [7:0] red
    typedef struct packed {
        t_kind       kind;
        logic [31:0] payload;
    } t_cmd;

endpackage
`default_nettype wire

// File: rtl/palette_pixel_unpacker_core.sv
// Top level of the palette pixel unpacker: front, command queue and back.
//
// Channel  Dir  Handshake                      Content
// cfg      in   i_cfg_we                       i_cfg_index, i_cfg_data (depth, row width)
// s_axis   in   s_axis_tvalid / s_axis_tready  palette entry or image data byte
// m_axis   out  m_axis_tvalid / m_axis_tready  RGBA pixel, row end, burst end
//
// Palette writes and data bytes at depths 8, 24 and 32 are taken one per cycle
// while the queue is not full. At depth 4 a byte gives two pixels and at depth 1
// eight, one pixel per cycle unless the output stalls, through the back sequencer
// and its palette read port; a row end cuts this short. A pixel passes the queue,
// the sequencer and lookup stages and the output register; the four-entry queue
// lets the front keep accepting while the output is stalled. Reset is synchronous
// and needs no clearing pass; palette entries are undefined until written.
`default_nettype none
module palette_pixel_unpacker_core
    import ppu_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [0:0]   i_cfg_index,
    input  wire [8:0]   i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] data_byte, [15:8] entry_index, [23:16] entry_blue,
    // [31:24] entry_green, [39:32] entry_red
    input  wire [39:0]  s_axis_tdata,
    // [0] op
    input  wire [0:0]   s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    output logic [31:0] m_axis_tdata,
    // row_end
    output logic        m_axis_tlast,
    // [0] burst_last
    output logic        m_axis_tuser
);

    logic       q_full;
    logic       q_push;
    t_cmd       q_in_cmd;
    logic       q_valid;
    t_cmd       q_out_cmd;
    logic       q_pop;
    logic [8:0] row_width;

    ppu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_cmd       (q_in_cmd),
        .o_row_width   (row_width)
    );

    ppu_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd),
        .i_pop   (q_pop)
    );

    ppu_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_row_width   (row_width),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_out_cmd),
        .o_q_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire

// File: rtl/ppu_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read.
`default_nettype none
module ppu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/ppu_cmd_fifo.sv
// Short command queue between the front and back parts of the unpacker.
`default_nettype none
module ppu_cmd_fifo
    import ppu_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    input  wire t_cmd   i_cmd,
    output logic        o_full,
    output logic        o_valid,
    output t_cmd        o_cmd,
    input  wire         i_pop
);

    localparam int PW = $clog2(C_QUEUE_DEPTH);

    t_cmd            r_mem [C_QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [PW:0]     r_count;

    assign o_full  = (r_count == (PW+1)'(C_QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/ppu_front.sv
// Front part: configuration registers, input acceptance and byte classification.
`default_nettype none
module ppu_front
    import ppu_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [0:0]   i_cfg_index,
    input  wire [8:0]   i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [39:0]  s_axis_tdata,
    input  wire [0:0]   s_axis_tuser,
    input  wire         i_q_full,
    output logic        o_q_push,
    output t_cmd        o_q_cmd,
    output logic [8:0]  o_row_width
);

    logic [5:0]  r_bpp;
    logic [8:0]  r_row_width;
    logic [1:0]  r_phase;
    logic [23:0] r_partial;
    logic [1:0]  n_phase;
    logic [23:0] n_partial;
    logic        accept;
    logic [7:0]  data_byte;

    assign s_axis_tready = !i_q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign data_byte     = s_axis_tdata[7:0];
    assign o_row_width   = r_row_width;

    always_comb begin
        o_q_push  = 1'b0;
        o_q_cmd   = '{kind: K_WRITE, payload: {s_axis_tdata[15:8], s_axis_tdata[23:16],
                                              s_axis_tdata[31:24], s_axis_tdata[39:32]}};
        n_phase   = r_phase;
        n_partial = r_partial;
        if (s_axis_tuser[0] == C_OP_PALETTE) begin
            o_q_push = accept;
        end else begin
            case (r_bpp)
                C_BPP_1: begin
                    o_q_push = accept;
                    o_q_cmd  = '{kind: K_IDX1, payload: {24'd0, data_byte}};
                end
                C_BPP_4: begin
                    o_q_push = accept;
                    o_q_cmd  = '{kind: K_IDX4, payload: {24'd0, data_byte}};
                end
                C_BPP_8: begin
                    o_q_push = accept;
                    o_q_cmd  = '{kind: K_IDX8, payload: {24'd0, data_byte}};
                end
                C_BPP_24: begin
                    o_q_cmd = '{kind: K_DIRECT, payload: {C_ALPHA_OPAQUE, r_partial[7:0],
                                                          r_partial[15:8], data_byte}};
                    if (r_phase[1]) begin
                        o_q_push  = accept;
                        n_phase   = 2'd0;
                        n_partial = 24'd0;
                    end else begin
                        n_phase = r_phase + 2'd1;
                        if (r_phase[0]) begin
                            n_partial[15:8] = data_byte;
                        end else begin
                            n_partial[7:0] = data_byte;
                        end
                    end
                end
                C_BPP_32: begin
                    o_q_cmd = '{kind: K_DIRECT, payload: {data_byte, r_partial[7:0],
                                                          r_partial[15:8], r_partial[23:16]}};
                    case (r_phase)
                        2'd0: n_partial[7:0]   = data_byte;
                        2'd1: n_partial[15:8]  = data_byte;
                        2'd2: n_partial[23:16] = data_byte;
                        default: begin
                            o_q_push  = accept;
                            n_partial = 24'd0;
                        end
                    endcase
                    n_phase = r_phase + 2'd1;
                end
                default: begin
                    o_q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp       <= C_BPP_RESET;
            r_row_width <= C_WIDTH_RESET;
            r_phase     <= 2'd0;
            r_partial   <= 24'd0;
        end else if (i_cfg_we) begin
            // A depth change restarts any multi-byte pixel in progress.
            if (i_cfg_index[0] == C_REG_BPP) begin
                r_bpp     <= i_cfg_data[5:0];
                r_phase   <= 2'd0;
                r_partial <= 24'd0;
            end else begin
                r_row_width <= i_cfg_data;
            end
        end else if (accept && s_axis_tuser[0] == C_OP_DATA) begin
            r_phase   <= n_phase;
            r_partial <= n_partial;
        end
    end

endmodule
`default_nettype wire

// File: rtl/ppu_back.sv
// Back part: palette store, pixel sequencer, column counter and output register.
`default_nettype none
module ppu_back
    import ppu_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire [8:0]   i_row_width,
    input  wire         i_q_valid,
    input  wire t_cmd   i_q_cmd,
    output logic        o_q_pop,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast,
    output logic        m_axis_tuser
);

    localparam int AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int WIDTH_CAP = (C_MAX_WIDTH > 511) ? 511 : C_MAX_WIDTH;

    // Sequencer stage.
    logic        r_cur_valid;
    t_cmd        r_cur;
    logic [2:0]  r_k;
    logic [8:0]  r_col;
    // Lookup stage, aligned with the RAM read data.
    logic        r_s2_valid;
    logic        r_s2_use_ram;
    logic        r_s2_oob;
    logic        r_s2_row_end;
    logic        r_s2_burst;
    logic [31:0] r_s2_rgba;
    // Output register.
    logic        r_o_valid;
    logic [31:0] r_o_data;
    logic        r_o_last;
    logic        r_o_user;

    logic [7:0]  cur_byte;
    logic [7:0]  pix_idx;
    logic [2:0]  last_k;
    logic        is_pix;
    logic        out_free;
    logic        s2_free;
    logic        issue;
    logic [9:0]  eff_w;
    logic        row_end;
    logic        last_pix;
    logic        cur_done;
    logic        cur_free;
    logic        ram_we;
    logic        ram_re;
    logic [23:0] ram_q;
    logic [23:0] lut_rgb;

    assign cur_byte = r_cur.payload[7:0];

    always_comb begin
        pix_idx = cur_byte;
        last_k  = 3'd0;
        case (r_cur.kind)
            K_IDX1: begin
                pix_idx = {7'd0, cur_byte[3'd7 - r_k]};
                last_k  = 3'd7;
            end
            K_IDX4: begin
                pix_idx = r_k[0] ? {4'd0, cur_byte[3:0]} : {4'd0, cur_byte[7:4]};
                last_k  = 3'd1;
            end
            default: begin
                pix_idx = cur_byte;
                last_k  = 3'd0;
            end
        endcase
    end

    always_comb begin
        if (i_row_width == 9'd0) begin
            eff_w = 10'd1;
        end else if ({1'b0, i_row_width} > 10'(WIDTH_CAP)) begin
            eff_w = 10'(WIDTH_CAP);
        end else begin
            eff_w = {1'b0, i_row_width};
        end
    end

    assign out_free = !r_o_valid || m_axis_tready;
    assign s2_free  = !r_s2_valid || out_free;
    assign is_pix   = r_cur_valid && (r_cur.kind != K_WRITE);
    assign issue    = is_pix && s2_free;
    assign row_end  = ({1'b0, r_col} + 10'd1) >= eff_w;
    // Pixels of a byte past the end of the row are dropped.
    assign last_pix = row_end || (r_k == last_k);
    assign cur_done = r_cur_valid && ((r_cur.kind == K_WRITE) || (issue && last_pix));
    assign cur_free = !r_cur_valid || cur_done;
    assign o_q_pop  = i_q_valid && cur_free;

    assign ram_we = r_cur_valid && (r_cur.kind == K_WRITE)
                    && ({1'b0, r_cur.payload[31:24]} < 9'(PALETTE_DEPTH));
    assign ram_re = issue && (r_cur.kind != K_DIRECT);

    ppu_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_colour_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cur.payload[AW+23:24]),
        .i_wdata (r_cur.payload[23:0]),
        .i_re    (ram_re),
        .i_raddr (pix_idx[AW-1:0]),
        .o_rdata (ram_q)
    );

    assign lut_rgb = r_s2_oob ? 24'd0 : ram_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_k         <= 3'd0;
            r_col       <= 9'd0;
            r_s2_valid  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (cur_free) begin
                r_cur_valid <= i_q_valid;
            end
            if (o_q_pop) begin
                r_k <= 3'd0;
            end else if (issue) begin
                r_k <= r_k + 3'd1;
            end
            if (issue) begin
                r_col <= row_end ? 9'd0 : r_col + 9'd1;
            end
            if (s2_free) begin
                r_s2_valid <= issue;
            end
            if (r_s2_valid && out_free) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_cmd;
        end
        if (issue) begin
            r_s2_use_ram <= (r_cur.kind != K_DIRECT);
            r_s2_oob     <= ({1'b0, pix_idx} >= 9'(PALETTE_DEPTH));
            r_s2_row_end <= row_end;
            r_s2_burst   <= last_pix;
            r_s2_rgba    <= r_cur.payload;
        end
        if (r_s2_valid && out_free) begin
            r_o_data <= r_s2_use_ram ? {C_ALPHA_OPAQUE, lut_rgb} : r_s2_rgba;
            r_o_last <= r_s2_row_end;
            r_o_user <= r_s2_burst;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = r_o_user;

    // A lookup issued now lands in the lookup stage on the next cycle.
    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> (r_s2_valid && r_s2_use_ram))
        else $error("palette read without a lookup stage entry");

    // The column counter never reaches 511, its all-ones value.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col != 9'h1FF)
        else $error("column counter out of range");

    // A row end always closes the pixels of its byte.
    a_row_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_last) |-> r_o_user)
        else $error("row end without burst end");

    // The pixel counter stays within the pixels of one byte.
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (r_k <= last_k))
        else $error("pixel counter beyond byte");

    // A palette write never coincides with a lookup.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("palette write and read in the same cycle");

endmodule
`default_nettype wire
